/* hw/rtl/assert_macros.svh */
// Assertion macros for the top level RTL file, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/u8cx_pkg.sv */
// Types, codes and constants of the UTF-8 character extractor.
`default_nettype none

package u8cx_pkg;

  localparam int unsigned WIN_BYTES = 4;
  localparam int unsigned USED_W    = 3;

  localparam logic [7:0] NUL_BYTE  = 8'h00;
  localparam logic [7:0] LAT_LEAD  = 8'hC2;
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic              from_latin1;
    status_t           status;
    logic [USED_W-1:0] consumed;
    win_t              chars;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/u8cx_in_reg.sv */
// Input register stage holding one byte window.
`default_nettype none

module u8cx_in_reg
  import u8cx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire win_t up_win,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output win_t      dn_win
);

  logic valid;
  win_t win;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_win   = win;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      win <= up_win;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/u8cx_decode.sv */
// Classification and extraction of one UTF-8 character from a byte window.
`default_nettype none

module u8cx_decode
  import u8cx_pkg::*;
(
  input  wire win_t win,
  output res_t      res
);

  logic c1;
  logic c2;
  logic c3;

  assign c1 = (win[1][7:6] == CONT_TAG);
  assign c2 = (win[2][7:6] == CONT_TAG);
  assign c3 = (win[3][7:6] == CONT_TAG);

  always_comb begin
    res = '{from_latin1: 1'b0, status: ST_BAD, consumed: '0, chars: '0};
    priority if (win[0] == NUL_BYTE) begin
      res.status = ST_END;
    end else if (!win[0][7]) begin
      res.status   = ST_OK;
      res.consumed = USED_W'(1);
      res.chars[0] = win[0];
    end else if (!c1) begin
      // re-encode a lone high byte as Latin-1
      res.status      = ST_OK;
      res.consumed    = USED_W'(1);
      res.from_latin1 = 1'b1;
      res.chars[0]    = LAT_LEAD + {7'd0, win[0][6]};
      res.chars[1]    = {CONT_TAG, win[0][5:0]};
    end else if (win[0][7:5] == LEAD2_TAG) begin
      res.status   = ST_OK;
      res.consumed = USED_W'(2);
      res.chars[0] = win[0];
      res.chars[1] = win[1];
    end else if ((win[0][7:4] == LEAD3_TAG) && c2) begin
      res.status   = ST_OK;
      res.consumed = USED_W'(3);
      res.chars[0] = win[0];
      res.chars[1] = win[1];
      res.chars[2] = win[2];
    end else if ((win[0][7:3] == LEAD4_TAG) && c2 && c3) begin
      res.status   = ST_OK;
      res.consumed = USED_W'(4);
      res.chars    = win;
    end else begin
      res.status = ST_BAD;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/u8cx_out_reg.sv */
// Result register stage holding one decoded character.
`default_nettype none

module u8cx_out_reg
  import u8cx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire res_t up_res,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output res_t      dn_res
);

  logic valid;
  res_t res;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      res <= up_res;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/utf8_char_extract_latin1_fallback_top.sv */
// Top level of the UTF-8 character extractor with Latin-1 fallback.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   byte0..byte3 (32 bits)                  -
//   m_axis    out  char_byte0..3, consumed (40 bits)       status, from_latin1
//
// One word per cycle sustained while m_axis_tready stays high; each word passes
// through the input register, the decoder and then the result register.
// Reset clears both stage valid flags; no clearing pass follows.
// A stall on m_axis fills the result register, then the input register, then
// drops s_axis_tready; both stages hold their words until taken.
`default_nettype none
`include "assert_macros.svh"

module utf8_char_extract_latin1_fallback_top
  import u8cx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // byte0, byte1, byte2, byte3
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // char_byte0..3, consumed, zero pad
  output logic [2:0]       m_axis_tuser   // status, from_latin1
);

  logic mid_valid;
  logic mid_ready;
  win_t mid_win;
  res_t dec_res;
  res_t out_res;

  u8cx_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_axis_tvalid),
    .up_ready (s_axis_tready),
    .up_win   (win_t'(s_axis_tdata)),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_win   (mid_win)
  );

  u8cx_decode u_decode (
    .win (mid_win),
    .res (dec_res)
  );

  u8cx_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_res   (dec_res),
    .dn_valid (m_axis_tvalid),
    .dn_ready (m_axis_tready),
    .dn_res   (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.consumed, out_res.chars};
  assign m_axis_tuser = {out_res.from_latin1, out_res.status};

  `ASSERT_CLK(a_used_iff_ok, m_axis_tvalid |-> ((out_res.consumed == '0) == (out_res.status != ST_OK)), "consumed count disagrees with status")
  `ASSERT_CLK(a_latin1_shape, (m_axis_tvalid && out_res.from_latin1) |-> (out_res.consumed == USED_W'(1) && out_res.status == ST_OK && out_res.chars[1][7:6] == CONT_TAG), "bad Latin-1 result")
  `ASSERT_CLK(a_fail_zero, (m_axis_tvalid && out_res.status != ST_OK) |-> (out_res.chars == '0 && !out_res.from_latin1), "end or error word carries data")
  `ASSERT_NEVER(a_mid_drop, mid_valid && !mid_ready && s_axis_tready, "input stage open while holding a stalled word")

endmodule

`default_nettype wire

/* tb/sv/utf8_char_extract_latin1_fallback_top_tb.sv */
// Testbench for the UTF-8 character extractor: bursty stream stimulus and a scoreboard.
`default_nettype none

module utf8_char_extract_latin1_fallback_top_tb
  import u8cx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    win_t              chars;
    logic [USED_W-1:0] consumed;
    status_t           status;
    logic              from_latin1;
  } char_result_t;

  class utf8_char_ledger;
    char_result_t pending_chars[$];
    int unsigned  errors;

    function new();
      errors = 0;
    endfunction

    function bit is_cont(logic [7:0] b);
      return b[7:6] == CONT_TAG;
    endfunction

    function char_result_t decode_window(win_t w);
      char_result_t r;
      r = '{chars: '0, consumed: '0, status: ST_BAD, from_latin1: 1'b0};
      if (w[0] == NUL_BYTE) begin
        r.status = ST_END;
      end else if (!w[0][7]) begin
        r.chars[0] = w[0];
        r.consumed = 3'd1;
        r.status   = ST_OK;
      end else if (!is_cont(w[1])) begin
        r.chars[0]    = LAT_LEAD + {7'd0, (w[0] > 8'hBF)};
        r.chars[1]    = {CONT_TAG, w[0][5:0]};
        r.consumed    = 3'd1;
        r.status      = ST_OK;
        r.from_latin1 = 1'b1;
      end else if (w[0][7:5] == LEAD2_TAG) begin
        r.chars[1:0] = w[1:0];
        r.consumed   = 3'd2;
        r.status     = ST_OK;
      end else if (w[0][7:4] == LEAD3_TAG && is_cont(w[2])) begin
        r.chars[2:0] = w[2:0];
        r.consumed   = 3'd3;
        r.status     = ST_OK;
      end else if (w[0][7:3] == LEAD4_TAG && is_cont(w[2]) && is_cont(w[3])) begin
        r.chars    = w;
        r.consumed = 3'd4;
        r.status   = ST_OK;
      end
      return r;
    endfunction

    function void note_window(win_t w);
      pending_chars.push_back(decode_window(w));
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction

    function void check_char(logic [39:0] data, logic [2:0] user);
      char_result_t want;
      if (pending_chars.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected word tdata=%h tuser=%h", $realtime, data, user);
        return;
      end
      want = pending_chars.pop_front();
      if (data[31:0] !== want.chars || data[34:32] !== want.consumed ||
          user[1:0] !== want.status || user[2] !== want.from_latin1) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: mismatch chars %h/%h consumed %0d/%0d status %0d/%0d latin1 %b/%b",
                   $realtime, want.chars, data[31:0], want.consumed, data[34:32],
                   want.status, user[1:0], want.from_latin1, user[2]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  utf8_char_ledger ledger = new();
  int unsigned     burst_left = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_count = 0;
  int unsigned     stall_mode = 0;

  utf8_char_extract_latin1_fallback_top uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) ledger.note_window(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) ledger.check_char(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    if (stall_count == 0) stall_mode <= $urandom_range(0, 4);
    stall_count <= (stall_count + 1) % 64;
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= stall_count[0];
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 9) >= 3);
      end
      3: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_axis_tready <= (stall_count >= 40);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic win_t pack_bytes(logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [7:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b[7:6] == CONT_TAG) b[6] = 1'b1;
    if ($urandom_range(0, 3) == 0) b = NUL_BYTE;
    return b;
  endfunction

  function automatic win_t well_formed(int unsigned len);
    win_t w;
    w = $urandom;
    case (len)
      2: begin
        w[0] = {LEAD2_TAG, 5'($urandom)};
      end
      3: begin
        w[0] = {LEAD3_TAG, 4'($urandom)};
      end
      default: begin
        w[0] = {LEAD4_TAG, 3'($urandom)};
      end
    endcase
    for (int unsigned i = 1; i < len; i++) w[i] = {CONT_TAG, 6'($urandom)};
    return w;
  endfunction

  function automatic win_t random_window();
    int unsigned pick;
    int unsigned len;
    win_t        w;
    pick = $urandom_range(0, 99);
    w = $urandom;
    if (pick < 8) begin
      w[0] = NUL_BYTE;
    end else if (pick < 20) begin
      w[0] = 8'($urandom_range(1, 127));
    end else if (pick < 60) begin
      w = well_formed($urandom_range(2, 4));
    end else if (pick < 72) begin
      w[0] = 8'($urandom_range(128, 255));
      w[1] = non_cont_byte();
    end else if (pick < 85) begin
      len = $urandom_range(3, 4);
      w = well_formed(len);
      w[$urandom_range(2, len - 1)] = non_cont_byte();
    end
    return w;
  endfunction

  task automatic push_word(win_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    win_t directed[$];
    directed = '{
      pack_bytes(8'h00, 8'hFF, 8'hFF, 8'hFF),
      pack_bytes(8'h00, 8'h00, 8'h00, 8'h00),
      pack_bytes(8'h01, 8'hFF, 8'hFF, 8'hFF),
      pack_bytes(8'h7F, 8'h80, 8'h80, 8'h80),
      pack_bytes(8'h80, 8'h00, 8'h80, 8'h80),
      pack_bytes(8'hBF, 8'h41, 8'h00, 8'h00),
      pack_bytes(8'hC0, 8'h00, 8'h00, 8'h00),
      pack_bytes(8'hFF, 8'hC0, 8'hFF, 8'hFF),
      pack_bytes(8'hE9, 8'h7F, 8'h80, 8'h80),
      pack_bytes(8'hC3, 8'hA9, 8'h00, 8'h00),
      pack_bytes(8'hC0, 8'h80, 8'hFF, 8'hFF),
      pack_bytes(8'hDF, 8'hBF, 8'h80, 8'h80),
      pack_bytes(8'hE2, 8'h82, 8'hAC, 8'h00),
      pack_bytes(8'hE0, 8'h80, 8'h00, 8'h80),
      pack_bytes(8'hEF, 8'hBF, 8'hC0, 8'h80),
      pack_bytes(8'hF0, 8'h9F, 8'h98, 8'h80),
      pack_bytes(8'hF7, 8'hBF, 8'hBF, 8'hBF),
      pack_bytes(8'hF4, 8'h8F, 8'hBF, 8'h00),
      pack_bytes(8'hF0, 8'h90, 8'h80, 8'h7F),
      pack_bytes(8'hF0, 8'h90, 8'h00, 8'h80),
      pack_bytes(8'h80, 8'h80, 8'h80, 8'h80),
      pack_bytes(8'hBF, 8'hBF, 8'h00, 8'h00),
      pack_bytes(8'hF8, 8'h80, 8'h80, 8'h80),
      pack_bytes(8'hFF, 8'hBF, 8'hBF, 8'hBF)
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) push_word(directed[i]);
    drain_results();
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      push_word(random_window());
      if (n == RANDOM_WORDS / 2) drain_results();
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
